@@ sv/med_pkg.sv @@
package med_pkg;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_TEXT  = 3'd1,
        PH_ESC   = 3'd2,
        PH_OCT   = 3'd3,
        PH_TRAIL = 3'd4,
        PH_ERR   = 3'd5
    } phase_t;

    localparam logic [1:0] ST_BYTE  = 2'd0;
    localparam logic [1:0] ST_OK    = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam int MAX_RESULTS    = 3;
    localparam int MAX_OCT_DIGITS = 3;
    localparam int RESQ_DEPTH     = 4;
    localparam int RESQ_AW        = $clog2(RESQ_DEPTH);
    localparam int RESQ_CW        = $clog2(RESQ_DEPTH + 1);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HT     = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       run_last;
    } result_t;

    // Results caused by one input byte, in order, slot 0 first
    typedef struct packed {
        logic [1:0]    count;
        result_t [2:0] res;
    } result_grp_t;

    function automatic logic is_octal(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_SEVEN);
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_HT) && (b <= CH_CR));
    endfunction

    function automatic logic [7:0] esc_map(input logic [7:0] b);
        logic [7:0] r;
        unique case (b)
            8'h6E:   r = 8'h0A; // n
            8'h74:   r = 8'h09; // t
            8'h76:   r = 8'h0B; // v
            8'h62:   r = 8'h08; // b
            8'h72:   r = 8'h0D; // r
            8'h66:   r = 8'h0C; // f
            default: r = b;
        endcase
        return r;
    endfunction

endpackage

@@ sv/med_ifs.sv @@
interface med_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_final;

    modport source (output valid, output in_byte, output is_final, input ready);
    modport sink (input valid, input in_byte, input is_final, output ready);
endinterface

interface med_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       run_last;

    modport source (output valid, output out_byte, output status, output run_last,
                    input ready);
    modport sink (input valid, input out_byte, input status, input run_last,
                  output ready);
endinterface

interface med_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] quote_char;

    modport source (output valid, output quote_char, input ready);
    modport sink (input valid, input quote_char, output ready);
endinterface

@@ sv/med_step.sv @@
module med_step
    import med_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  in_byte,
    input  logic        is_final,
    input  logic [7:0]  quote_char,
    output result_grp_t grp
);

    phase_t     phase_reg, phase_next;
    logic [8:0] oval_reg, oval_next;
    logic [1:0] odig_reg, odig_next;
    logic       inq_reg, inq_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            oval_reg  <= '0;
            odig_reg  <= '0;
            inq_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            oval_reg  <= oval_next;
            odig_reg  <= odig_next;
            inq_reg   <= inq_next;
        end
    end

    always_comb
    begin
        result_t [3:0] res;
        logic [1:0]    n;
        logic          do_text;
        logic          close_oct;
        logic          text_after;
        logic [7:0]    okv;
        logic [1:0]    st;

        phase_next = phase_reg;
        oval_next  = oval_reg;
        odig_next  = odig_reg;
        inq_next   = inq_reg;
        res        = '0;
        n          = '0;
        do_text    = 1'b0;
        close_oct  = 1'b0;
        text_after = 1'b0;
        okv        = '0;
        st         = ST_ERROR;

        unique case (phase_reg)
            PH_START:
            begin
                inq_next   = 1'b0;
                phase_next = PH_TEXT;
                if ((quote_char != CH_NUL) && (in_byte == quote_char))
                    inq_next = 1'b1;
                else
                    do_text = 1'b1;
            end
            PH_TEXT:
                do_text = 1'b1;
            PH_ESC:
            begin
                if (is_octal(in_byte))
                begin
                    oval_next  = {6'd0, in_byte[2:0]};
                    odig_next  = 2'd1;
                    phase_next = PH_OCT;
                end
                else if (in_byte == CH_NUL)
                    phase_next = PH_ERR;
                else
                begin
                    res[n] = '{out_byte: esc_map(in_byte), status: ST_BYTE, run_last: 1'b0};
                    n = n + 2'd1;
                    phase_next = PH_TEXT;
                end
            end
            PH_OCT:
            begin
                if (is_octal(in_byte) && (odig_reg < 2'(MAX_OCT_DIGITS)))
                begin
                    oval_next = {oval_reg[5:0], in_byte[2:0]};
                    odig_next = odig_reg + 2'd1;
                    if (odig_next == 2'(MAX_OCT_DIGITS))
                        close_oct = 1'b1;
                end
                else
                begin
                    close_oct  = 1'b1;
                    text_after = 1'b1;
                end
            end
            PH_TRAIL:
            begin
                if (!is_blank(in_byte))
                    phase_next = PH_ERR;
            end
            default:
                phase_next = PH_ERR;
        endcase

        // End the octal run: a zero byte is an error, anything else is emitted
        if (close_oct)
        begin
            okv       = oval_next[7:0];
            oval_next = '0;
            odig_next = '0;
            if (okv == CH_NUL)
                phase_next = PH_ERR;
            else
            begin
                res[n] = '{out_byte: okv, status: ST_BYTE, run_last: 1'b0};
                n = n + 2'd1;
                phase_next = PH_TEXT;
            end
        end

        // The byte that ended an octal run is then taken as plain text
        if (text_after && (phase_next == PH_TEXT))
            do_text = 1'b1;

        if (do_text)
        begin
            if (inq_next && (quote_char != CH_NUL) && (in_byte == quote_char))
                phase_next = PH_TRAIL;
            else if (in_byte == CH_NUL)
                phase_next = PH_ERR;
            else if (in_byte == CH_BSLASH)
                phase_next = PH_ESC;
            else
            begin
                res[n] = '{out_byte: in_byte, status: ST_BYTE, run_last: 1'b0};
                n = n + 2'd1;
            end
        end

        if (is_final)
        begin
            if (phase_next == PH_OCT)
            begin
                okv = oval_next[7:0];
                if (okv == CH_NUL)
                    phase_next = PH_ERR;
                else
                begin
                    res[n] = '{out_byte: okv, status: ST_BYTE, run_last: 1'b0};
                    n = n + 2'd1;
                    phase_next = PH_TEXT;
                end
            end
            if (phase_next == PH_TEXT)
                st = inq_next ? ST_ERROR : ST_OK;
            else if (phase_next == PH_TRAIL)
                st = ST_OK;
            else
                st = ST_ERROR;
            res[n] = '{out_byte: CH_NUL, status: st, run_last: 1'b0};
            n = n + 2'd1;
            phase_next = PH_START;
            oval_next  = '0;
            odig_next  = '0;
            inq_next   = 1'b0;
        end

        if (n != 2'd0)
            res[n - 2'd1].run_last = 1'b1;

        grp.count = n;
        grp.res   = res[2:0];
    end

endmodule

@@ sv/med_resq.sv @@
module med_resq
    import med_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  result_grp_t grp,
    output logic        space,
    output logic        head_valid,
    input  logic        head_ready,
    output result_t     head
);

    result_t              mem [RESQ_DEPTH];
    logic [RESQ_CW-1:0]   count_reg, count_next;
    logic [RESQ_AW-1:0]   rd_ptr_reg, wr_ptr_reg;
    logic [RESQ_CW-1:0]   push_cnt;
    logic                 pop;

    assign pop        = (count_reg != '0) && head_ready;
    assign push_cnt   = push ? RESQ_CW'(grp.count) : '0;
    assign count_next = count_reg + push_cnt - RESQ_CW'(pop);
    // Room for the largest group whatever the sink does this cycle
    assign space      = count_reg <= RESQ_CW'(RESQ_DEPTH - MAX_RESULTS);
    assign head_valid = count_reg != '0;
    assign head       = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_reg + RESQ_AW'(pop);
            wr_ptr_reg <= wr_ptr_reg + RESQ_AW'(push_cnt);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (push && (i < int'(grp.count)))
                mem[wr_ptr_reg + RESQ_AW'(i)] <= grp.res[i];
        end
    end

endmodule

@@ sv/message_escape_decoder.sv @@
// C-style escape decoder for message text. One raw byte is taken per transfer on in_ch,
// with is_final on the last byte of a message; decoded bytes leave on out_ch with status 0,
// and every message closes with one status result, 1 for ok or 2 for error (after an error
// the bytes already sent belong to a message that must be dropped). Each byte updates the
// decoder state in the cycle it is taken and its results (none to three) go into a 4-entry
// result queue that drives out_ch; a new byte is taken whenever the queue holds at most one
// result, so one byte per cycle is sustained while each byte gives at most one result and the
// receiver is ready on out_ch, and the single output port, one result per cycle, sets the pace
// otherwise. quote_char is written on cfg and is applied from the next byte on.
module message_escape_decoder
    import med_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    med_in_if.sink    in_ch,
    med_out_if.source out_ch,
    med_cfg_if.sink   cfg
);

    logic        [7:0] quote_reg;
    logic              accept;
    logic              space;
    result_grp_t       grp;
    result_t           head;

    assign cfg.ready   = 1'b1;
    assign in_ch.ready = space;
    assign accept      = in_ch.valid && space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quote_reg <= '0;
        else if (cfg.valid)
            quote_reg <= cfg.quote_char;
    end

    med_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_ch.in_byte),
        .is_final   (in_ch.is_final),
        .quote_char (quote_reg),
        .grp        (grp)
    );

    med_resq u_resq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .grp        (grp),
        .space      (space),
        .head_valid (out_ch.valid),
        .head_ready (out_ch.ready),
        .head       (head)
    );

    assign out_ch.out_byte = head.out_byte;
    assign out_ch.status   = head.status;
    assign out_ch.run_last = head.run_last;

endmodule

@@ sv/med_check.sv @@
module med_check
    import med_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic [1:0] status,
    input logic       run_last
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status)
            && $stable(run_last))
        else $error("stalled result changed");

    // A message status always closes the run of its input byte
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_BYTE) |-> run_last)
        else $error("status result not last of its run");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_BYTE) || (status == ST_OK) || (status == ST_ERROR))
        else $error("undefined status code");

    // Decoded text never carries NUL; status results carry zero
    a_no_nul: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_BYTE) |-> out_byte != CH_NUL)
        else $error("NUL byte emitted");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_BYTE) |-> out_byte == CH_NUL)
        else $error("status result with nonzero byte");

endmodule

bind message_escape_decoder med_check u_med_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .status    (out_ch.status),
    .run_last  (out_ch.run_last)
);

@@ tb/med_checker.sv @@
module med_checker
    import med_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    med_in_if    in_ch,
    med_out_if   out_ch,
    med_cfg_if   cfg,
    output int   fail_count,
    output int   pending
);

    result_t    due_results[$];
    result_t    step_results[$];
    phase_t     ph;
    logic [8:0] oct_val;
    logic [1:0] oct_cnt;
    logic       quoted;
    logic [7:0] quote_byte;
    int         errs;

    function automatic logic octal_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_SEVEN);
    endfunction

    function automatic logic [7:0] escaped(input logic [7:0] b);
        case (b)
            "n":     return 8'h0A;
            "t":     return 8'h09;
            "v":     return 8'h0B;
            "b":     return 8'h08;
            "r":     return 8'h0D;
            "f":     return 8'h0C;
            default: return b;
        endcase
    endfunction

    task automatic put(input logic [7:0] b, input logic [1:0] st);
        result_t r;
        r.out_byte = b;
        r.status   = st;
        r.run_last = 1'b0;
        step_results.push_back(r);
    endtask

    // A zero value ends the run in error rather than emitting a byte
    task automatic close_octal();
        logic [7:0] v;
        v       = oct_val[7:0];
        oct_val = '0;
        oct_cnt = '0;
        if (v == CH_NUL)
        begin
            ph = PH_ERR;
        end
        else
        begin
            put(v, ST_BYTE);
            ph = PH_TEXT;
        end
    endtask

    // Closing quote is tested before the backslash
    task automatic text_char(input logic [7:0] b);
        if (quoted && quote_byte != CH_NUL && b == quote_byte)
            ph = PH_TRAIL;
        else if (b == CH_NUL)
            ph = PH_ERR;
        else if (b == CH_BSLASH)
            ph = PH_ESC;
        else
            put(b, ST_BYTE);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic fin);
        logic [1:0] st;
        step_results.delete();
        case (ph)
            PH_START:
            begin
                quoted = 1'b0;
                ph     = PH_TEXT;
                if (quote_byte != CH_NUL && b == quote_byte)
                    quoted = 1'b1;
                else
                    text_char(b);
            end
            PH_TEXT:
                text_char(b);
            PH_ESC:
            begin
                if (octal_digit(b))
                begin
                    oct_val = 9'(b - CH_ZERO);
                    oct_cnt = 2'd1;
                    ph      = PH_OCT;
                end
                else if (b == CH_NUL)
                begin
                    ph = PH_ERR;
                end
                else
                begin
                    put(escaped(b), ST_BYTE);
                    ph = PH_TEXT;
                end
            end
            PH_OCT:
            begin
                if (octal_digit(b) && oct_cnt < MAX_OCT_DIGITS)
                begin
                    oct_val = 9'({oct_val, 3'b000} + (b - CH_ZERO));
                    oct_cnt = oct_cnt + 2'd1;
                    if (oct_cnt >= MAX_OCT_DIGITS)
                        close_octal();
                end
                else
                begin
                    // Decode the byte that ended the run as ordinary text
                    close_octal();
                    if (ph == PH_TEXT)
                        text_char(b);
                end
            end
            PH_TRAIL:
            begin
                if (!(b == CH_SPACE || (b >= CH_HT && b <= CH_CR)))
                    ph = PH_ERR;
            end
            default:
                ph = PH_ERR;
        endcase
        if (fin)
        begin
            if (ph == PH_OCT)
                close_octal();
            if (ph == PH_TEXT)
                st = quoted ? ST_ERROR : ST_OK;
            else if (ph == PH_TRAIL)
                st = ST_OK;
            else
                st = ST_ERROR;
            put(8'h00, st);
            ph      = PH_START;
            oct_val = '0;
            oct_cnt = '0;
            quoted  = 1'b0;
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].run_last = 1'b1;
        foreach (step_results[i])
            due_results.push_back(step_results[i]);
    endtask

    task automatic check_result();
        result_t want;
        if (due_results.size() == 0)
        begin
            $error("result with nothing due: out_byte %0h status %0d run_last %0b",
                   out_ch.out_byte, out_ch.status, out_ch.run_last);
            errs++;
        end
        else
        begin
            want = due_results.pop_front();
            if (out_ch.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %0h, got %0h", want.out_byte, out_ch.out_byte);
                errs++;
            end
            if (out_ch.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, out_ch.status);
                errs++;
            end
            if (out_ch.run_last !== want.run_last)
            begin
                $error("run_last: expected %0b, got %0b", want.run_last, out_ch.run_last);
                errs++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph         = PH_START;
            oct_val    = '0;
            oct_cnt    = '0;
            quoted     = 1'b0;
            quote_byte = CH_NUL;
            errs       = 0;
            due_results.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                decode_byte(in_ch.in_byte, in_ch.is_final);
            // A new quote byte applies from the next transfer on
            if (cfg.valid && cfg.ready)
                quote_byte = cfg.quote_char;
            if (out_ch.valid && out_ch.ready)
                check_result();
            fail_count <= errs;
            pending    <= due_results.size();
        end
    end

endmodule

@@ tb/message_escape_decoder_tb.sv @@
module message_escape_decoder_tb;
    import med_pkg::*;

    localparam int HOLD_CYCLES   = 200;
    localparam int IDLE_LIMIT    = 2000;
    localparam int PHASE_ITEMS   = 110;
    localparam int SETTLE_CYCLES = 4;

    localparam logic [7:0]  CH_DQUOTE   = 8'h22;
    localparam logic [7:0]  CH_SQUOTE   = 8'h27;
    localparam logic [7:0]  CH_TOP      = 8'hFF;
    localparam logic [47:0] ESC_LETTERS = "ntvbrf";

    // Bit 8 marks the final byte of a message
    localparam logic [8:0] DIRECTED [29] = '{
        9'h0FF, 9'h05C, 9'h06E, 9'h05C, 9'h031, 9'h032, 9'h033, 9'h134,
        9'h05C, 9'h034, 9'h030, 9'h130,
        9'h05C, 9'h137,
        9'h15C,
        9'h05C, 9'h100,
        9'h100,
        9'h122,
        9'h022, 9'h05C, 9'h022, 9'h022, 9'h10D,
        9'h022, 9'h178,
        9'h022, 9'h022, 9'h179
    };

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_t;
    typedef enum {TK_PLAIN, TK_LETTER, TK_OTHER, TK_OCTAL, TK_NOISE} token_t;

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;
    int         fail_count;
    int         pending;
    int         hold_asks   = 0;
    int         idle_cycles = 0;
    int         burst_left  = 0;
    bit         offering    = 1'b0;
    logic [7:0] msg_bytes[$];

    med_in_if  in_ch();
    med_out_if out_ch();
    med_cfg_if cfg();

    message_escape_decoder i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    med_checker i_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg.valid && cfg.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: changing stall patterns, with a long hold-off on request
    initial
    begin
        rx_mode_t mode;
        int       span;
        int       tick;
        int       holds_served;
        mode         = RX_OPEN;
        span         = 0;
        tick         = 0;
        holds_served = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != holds_served)
            begin
                holds_served++;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                if (span == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    span = $urandom_range(5, 60);
                end
                span--;
                tick++;
                case (mode)
                    RX_OPEN:   out_ch.ready <= 1'b1;
                    RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:   out_ch.ready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic fin);
        int gap;
        in_ch.valid    <= 1'b1;
        in_ch.in_byte  <= b;
        in_ch.is_final <= fin;
        offering = 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20)
                                                     : $urandom_range(0, 3);
            burst_left = $urandom_range(0, 30);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                offering = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Hold the input until every due result has been checked
    task automatic settle();
        if (offering)
        begin
            in_ch.valid <= 1'b0;
            offering = 1'b0;
        end
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_quote(input logic [7:0] q);
        cfg.valid      <= 1'b1;
        cfg.quote_char <= q;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [7:0] plain_char(input logic [7:0] q);
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == CH_BSLASH || c == q);
        return c;
    endfunction

    // Mostly well-formed text; a share of noise, zero values and broken endings
    task automatic compose_message(input logic [7:0] q);
        logic       quoted_msg;
        logic [7:0] c;
        int         r;
        token_t     tok;
        msg_bytes.delete();
        quoted_msg = (q != CH_NUL) && ($urandom_range(0, 1) == 1);
        if (quoted_msg)
            msg_bytes.push_back(q);
        repeat ($urandom_range(0, 10))
        begin
            r   = $urandom_range(0, 9);
            tok = (r < 4) ? TK_PLAIN : (r < 6) ? TK_LETTER : (r < 7) ? TK_OTHER
                : (r < 9) ? TK_OCTAL : TK_NOISE;
            case (tok)
                TK_PLAIN:
                    msg_bytes.push_back(plain_char(q));
                TK_LETTER:
                begin
                    msg_bytes.push_back(CH_BSLASH);
                    msg_bytes.push_back(ESC_LETTERS[8 * $urandom_range(0, 5) +: 8]);
                end
                TK_OTHER:
                begin
                    do c = 8'($urandom_range(1, 255)); while (c >= CH_ZERO && c <= CH_SEVEN);
                    msg_bytes.push_back(CH_BSLASH);
                    msg_bytes.push_back(c);
                end
                TK_OCTAL:
                begin
                    msg_bytes.push_back(CH_BSLASH);
                    msg_bytes.push_back(($urandom_range(0, 15) == 0)
                                        ? CH_ZERO : 8'(CH_ZERO + $urandom_range(1, 7)));
                    repeat ($urandom_range(0, 2))
                        msg_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 7)));
                end
                default:
                    msg_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        if (quoted_msg)
        begin
            // Drop the closing quote now and then
            if ($urandom_range(0, 9) != 0)
            begin
                msg_bytes.push_back(q);
                repeat ($urandom_range(0, 2))
                    msg_bytes.push_back(($urandom_range(0, 5) == 0)
                                        ? CH_SPACE : 8'(CH_HT + $urandom_range(0, 4)));
                if ($urandom_range(0, 9) == 0)
                    msg_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        else if ($urandom_range(0, 19) == 0)
        begin
            msg_bytes.push_back(CH_BSLASH);
        end
        if (msg_bytes.size() == 0)
            msg_bytes.push_back(plain_char(q));
    endtask

    task automatic run_phase(input logic [7:0] q, input bit with_hold);
        int sent;
        bit held;
        sent = 0;
        held = 1'b0;
        write_quote(q);
        while (sent < PHASE_ITEMS)
        begin
            compose_message(q);
            if (with_hold && !held && sent >= PHASE_ITEMS / 3)
            begin
                // Keep offering without gaps while the receiver holds off
                hold_asks <= hold_asks + 1;
                burst_left = HOLD_CYCLES;
                held       = 1'b1;
            end
            foreach (msg_bytes[i])
                send_item(msg_bytes[i], i == msg_bytes.size() - 1);
            sent += msg_bytes.size();
        end
        settle();
    endtask

    initial
    begin
        in_ch.valid    = 1'b0;
        in_ch.in_byte  = 8'h00;
        in_ch.is_final = 1'b0;
        cfg.valid      = 1'b0;
        cfg.quote_char = 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        write_quote(CH_DQUOTE);
        foreach (DIRECTED[i])
            send_item(DIRECTED[i][7:0], DIRECTED[i][8]);
        settle();
        run_phase(CH_NUL, 1'b0);
        run_phase(CH_TOP, 1'b1);
        run_phase(8'($urandom_range(1, 254)), 1'b0);
        run_phase(CH_SQUOTE, 1'b1);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
